### rtl/kerq_pkg.sv
// package for the key event release queue: payload types, codes and sizes
package kerq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DEFER_DEPTH = 16;
  localparam int KEY_COUNT   = 256;
  localparam int OBUF_DEPTH  = QUEUE_DEPTH + DEFER_DEPTH;
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int DIW = $clog2(DEFER_DEPTH);
  localparam int DCW = $clog2(DEFER_DEPTH + 1);
  localparam int OIW = $clog2(OBUF_DEPTH);
  localparam int OCW = $clog2(OBUF_DEPTH + 1);

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_code;
    logic        is_press;
    logic [31:0] event_time;
    logic [31:0] boundary_time;
  } in_item_t;

  typedef struct packed {
    logic        has_event;
    logic [7:0]  out_key;
    logic        out_press;
    logic [31:0] out_time;
    logic        last;
    logic [5:0]  pending_count;
    logic [31:0] dropped_total;
    logic        key_state;
    logic        defer_overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_STEP_INC,
    CMD_FLUSH,
    CMD_SCAN_CLR,
    CMD_OLD_EVAL,
    CMD_Q_EVAL,
    CMD_PUSH_WR,
    CMD_DEF_EVAL,
    CMD_PICK,
    CMD_CANCEL_EVAL,
    CMD_REL_DEC,
    CMD_OUT_RD,
    CMD_OUT_NEXT
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_OLD_SCAN,
    S_PUSH_WR,
    S_DEF,
    S_Q_START,
    S_Q_SCAN,
    S_Q_PICK,
    S_CANCEL,
    S_REL,
    S_OUT_RD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       q_last;
    logic       def_done;
    logic       found;
    logic       best_press;
    logic       out_last;
  } dp_status_t;

endpackage

### rtl/kerq_ctrl.sv
// controller state machine sequencing the queue datapath
module kerq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  kerq_pkg::dp_status_t   status,
  output kerq_pkg::cmd_t         cmd
);

  kerq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kerq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kerq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = kerq_pkg::S_DISPATCH;
      end
      kerq_pkg::S_DISPATCH: begin
        case (status.mode)
          kerq_pkg::MODE_PUSH: begin
            state_nxt = status.full ? kerq_pkg::S_OLD_SCAN : kerq_pkg::S_PUSH_WR;
          end
          kerq_pkg::MODE_STEP: state_nxt = kerq_pkg::S_DEF;
          default:             state_nxt = kerq_pkg::S_OUT_RD;
        endcase
      end
      kerq_pkg::S_OLD_SCAN: begin
        if (status.q_last) state_nxt = kerq_pkg::S_PUSH_WR;
      end
      kerq_pkg::S_PUSH_WR: state_nxt = kerq_pkg::S_OUT_RD;
      kerq_pkg::S_DEF: begin
        if (status.def_done) state_nxt = kerq_pkg::S_Q_START;
      end
      kerq_pkg::S_Q_START: state_nxt = kerq_pkg::S_Q_SCAN;
      kerq_pkg::S_Q_SCAN: begin
        if (status.q_last) state_nxt = kerq_pkg::S_Q_PICK;
      end
      kerq_pkg::S_Q_PICK: begin
        if (!status.found) state_nxt = kerq_pkg::S_OUT_RD;
        else if (status.best_press) state_nxt = kerq_pkg::S_CANCEL;
        else state_nxt = kerq_pkg::S_REL;
      end
      kerq_pkg::S_CANCEL: begin
        if (status.def_done) state_nxt = kerq_pkg::S_Q_START;
      end
      kerq_pkg::S_REL: state_nxt = kerq_pkg::S_Q_START;
      kerq_pkg::S_OUT_RD: state_nxt = kerq_pkg::S_OUT;
      kerq_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = status.out_last ? kerq_pkg::S_IDLE : kerq_pkg::S_OUT_RD;
        end
      end
      default: state_nxt = kerq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = kerq_pkg::CMD_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      kerq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd = kerq_pkg::CMD_LATCH;
      end
      kerq_pkg::S_DISPATCH: begin
        case (status.mode)
          kerq_pkg::MODE_PUSH:  cmd = kerq_pkg::CMD_SCAN_CLR;
          kerq_pkg::MODE_STEP:  cmd = kerq_pkg::CMD_STEP_INC;
          kerq_pkg::MODE_FLUSH: cmd = kerq_pkg::CMD_FLUSH;
          default:              cmd = kerq_pkg::CMD_NONE;
        endcase
      end
      kerq_pkg::S_OLD_SCAN: cmd = kerq_pkg::CMD_OLD_EVAL;
      kerq_pkg::S_PUSH_WR:  cmd = kerq_pkg::CMD_PUSH_WR;
      kerq_pkg::S_DEF: begin
        if (!status.def_done) cmd = kerq_pkg::CMD_DEF_EVAL;
      end
      kerq_pkg::S_Q_START: cmd = kerq_pkg::CMD_SCAN_CLR;
      kerq_pkg::S_Q_SCAN:  cmd = kerq_pkg::CMD_Q_EVAL;
      kerq_pkg::S_Q_PICK: begin
        if (status.found) cmd = kerq_pkg::CMD_PICK;
      end
      kerq_pkg::S_CANCEL: begin
        if (!status.def_done) cmd = kerq_pkg::CMD_CANCEL_EVAL;
      end
      kerq_pkg::S_REL:    cmd = kerq_pkg::CMD_REL_DEC;
      kerq_pkg::S_OUT_RD: cmd = kerq_pkg::CMD_OUT_RD;
      kerq_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall && !status.out_last) cmd = kerq_pkg::CMD_OUT_NEXT;
      end
      default: cmd = kerq_pkg::CMD_NONE;
    endcase
  end

endmodule

### rtl/kerq_dp.sv
// datapath: event queue, deferral table, key tables and result buffer
module kerq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kerq_pkg::cmd_t       cmd,
  input  kerq_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  output kerq_pkg::dp_status_t status,
  output kerq_pkg::out_item_t  out_data
);

  localparam int QD  = kerq_pkg::QUEUE_DEPTH;
  localparam int DD  = kerq_pkg::DEFER_DEPTH;
  localparam int QIW = kerq_pkg::QIW;
  localparam int DIW = kerq_pkg::DIW;
  localparam int DCW = kerq_pkg::DCW;
  localparam int OIW = kerq_pkg::OIW;
  localparam int OCW = kerq_pkg::OCW;

  // control state
  logic [15:0]     min_hold_r;
  logic [QD-1:0]   qvalid_r;
  logic [DCW-1:0]  dcount_r;
  logic [31:0]     next_order_r;
  logic [31:0]     step_r;
  logic [31:0]     drop_r;
  logic [kerq_pkg::KEY_COUNT-1:0] press_seen_r;
  logic [kerq_pkg::KEY_COUNT-1:0] key_pressed_r;
  logic            overflow_r;
  logic            qstate_r;
  logic [QIW-1:0]  q_i_r;
  logic            found_r;
  logic [DCW-1:0]  d_i_r;
  logic [OCW-1:0]  ocount_r;
  logic [OIW-1:0]  rd_idx_r;

  // payload
  logic [1:0]      mode_r;
  logic [7:0]      key_r;
  logic            press_r;
  logic [31:0]     time_r;
  logic [31:0]     bnd_r;
  logic [31:0]     qtime_r  [QD];
  logic [7:0]      qkey_r   [QD];
  logic            qpress_r [QD];
  logic [31:0]     qorder_r [QD];
  logic [7:0]      dkey_r   [DD];
  logic [31:0]     dtime_r  [DD];
  logic [31:0]     ddue_r   [DD];
  logic [QIW-1:0]  best_idx_r;
  logic [31:0]     best_time_r;
  logic [31:0]     best_age_r;
  logic [7:0]      best_key_r;
  logic            best_press_r;
  logic [31:0]     ps_q_r;
  logic [40:0]     rdata_r;
  logic [31:0]     press_step_mem [kerq_pkg::KEY_COUNT];
  logic [40:0]     obuf_mem [kerq_pkg::OBUF_DEPTH];

  // combinational
  logic [31:0]     q_age;
  logic            q_cand;
  logic            q_better;
  logic            old_better;
  logic [DIW-1:0]  d_idx;
  logic [31:0]     d_diff;
  logic            d_due;
  logic            d_match;
  logic            full;
  logic [QIW-1:0]  free_slot;
  logic [QIW-1:0]  wr_slot;
  logic [31:0]     held;
  logic            defer_req;
  logic            dtab_full;
  logic            emit_en;
  logic [7:0]      emit_key;
  logic            emit_press;
  logic [31:0]     emit_time;
  logic            rm_en;
  logic            app_en;
  logic [5:0]      qpop;

  assign q_age      = next_order_r - qorder_r[q_i_r];
  assign q_cand     = qvalid_r[q_i_r] && (qtime_r[q_i_r] < bnd_r);
  assign q_better   = !found_r || (qtime_r[q_i_r] < best_time_r) ||
                      ((qtime_r[q_i_r] == best_time_r) && (q_age > best_age_r));
  assign old_better = !found_r || (q_age > best_age_r);
  assign d_idx      = d_i_r[DIW-1:0];
  assign d_diff     = step_r - ddue_r[d_idx];
  assign d_due      = !d_diff[31];
  assign d_match    = (dkey_r[d_idx] == best_key_r);
  assign full       = &qvalid_r;
  assign wr_slot    = full ? best_idx_r : free_slot;
  assign held       = step_r - ps_q_r;
  assign dtab_full  = (dcount_r == DCW'(DD));
  assign defer_req  = (min_hold_r != 16'd0) && press_seen_r[best_key_r] &&
                      (held < {16'd0, min_hold_r});

  always_comb begin
    free_slot = '0;
    for (int i = QD - 1; i >= 0; i--) begin
      if (!qvalid_r[i]) free_slot = QIW'(i);
    end
  end

  always_comb begin
    qpop = '0;
    for (int i = 0; i < QD; i++) begin
      qpop = qpop + 6'(qvalid_r[i]);
    end
  end

  // released event and deferral table edits
  always_comb begin
    emit_en    = 1'b0;
    emit_key   = best_key_r;
    emit_press = 1'b0;
    emit_time  = best_time_r;
    rm_en      = 1'b0;
    app_en     = 1'b0;
    case (cmd)
      kerq_pkg::CMD_DEF_EVAL: begin
        if (d_due) begin
          emit_en   = 1'b1;
          emit_key  = dkey_r[d_idx];
          emit_time = dtime_r[d_idx];
          rm_en     = 1'b1;
        end
      end
      kerq_pkg::CMD_PICK: begin
        if (best_press_r) begin
          emit_en    = 1'b1;
          emit_press = 1'b1;
        end
      end
      kerq_pkg::CMD_CANCEL_EVAL: begin
        rm_en = d_match;
      end
      kerq_pkg::CMD_REL_DEC: begin
        if (defer_req && !dtab_full) app_en = 1'b1;
        else emit_en = 1'b1;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hold_r    <= '0;
      qvalid_r      <= '0;
      dcount_r      <= '0;
      next_order_r  <= '0;
      step_r        <= '0;
      drop_r        <= '0;
      press_seen_r  <= '0;
      key_pressed_r <= '0;
      overflow_r    <= 1'b0;
      qstate_r      <= 1'b0;
      q_i_r         <= '0;
      found_r       <= 1'b0;
      d_i_r         <= '0;
      ocount_r      <= '0;
      rd_idx_r      <= '0;
    end else begin
      if (cfg_we) min_hold_r <= cfg_data;
      case (cmd)
        kerq_pkg::CMD_LATCH: begin
          qstate_r <= (in_data.mode == kerq_pkg::MODE_QUERY) &&
                      key_pressed_r[in_data.key_code];
          ocount_r <= '0;
          rd_idx_r <= '0;
          d_i_r    <= '0;
        end
        kerq_pkg::CMD_STEP_INC: step_r <= step_r + 32'd1;
        kerq_pkg::CMD_FLUSH: begin
          qvalid_r <= '0;
          dcount_r <= '0;
        end
        kerq_pkg::CMD_SCAN_CLR: begin
          q_i_r   <= '0;
          found_r <= 1'b0;
        end
        kerq_pkg::CMD_OLD_EVAL: begin
          if (old_better) found_r <= 1'b1;
          q_i_r <= q_i_r + QIW'(1);
        end
        kerq_pkg::CMD_Q_EVAL: begin
          if (q_cand && q_better) found_r <= 1'b1;
          q_i_r <= q_i_r + QIW'(1);
        end
        kerq_pkg::CMD_PUSH_WR: begin
          if (full && drop_r != 32'hFFFF_FFFF) drop_r <= drop_r + 32'd1;
          qvalid_r[wr_slot] <= 1'b1;
          next_order_r      <= next_order_r + 32'd1;
        end
        kerq_pkg::CMD_DEF_EVAL,
        kerq_pkg::CMD_CANCEL_EVAL: begin
          if (rm_en) dcount_r <= dcount_r - DCW'(1);
          else d_i_r <= d_i_r + DCW'(1);
        end
        kerq_pkg::CMD_PICK: begin
          qvalid_r[best_idx_r] <= 1'b0;
          if (best_press_r) press_seen_r[best_key_r] <= 1'b1;
          d_i_r <= '0;
        end
        kerq_pkg::CMD_REL_DEC: begin
          if (app_en) dcount_r <= dcount_r + DCW'(1);
          else if (defer_req) overflow_r <= 1'b1;
        end
        kerq_pkg::CMD_OUT_NEXT: rd_idx_r <= rd_idx_r + OIW'(1);
        default: begin
          found_r <= found_r;
        end
      endcase
      if (emit_en) begin
        ocount_r <= ocount_r + OCW'(1);
        key_pressed_r[emit_key] <= emit_press;
      end
    end
  end

  // payload registers and tables
  always_ff @(posedge clk) begin
    case (cmd)
      kerq_pkg::CMD_LATCH: begin
        mode_r  <= in_data.mode;
        key_r   <= in_data.key_code;
        press_r <= in_data.is_press;
        time_r  <= in_data.event_time;
        bnd_r   <= in_data.boundary_time;
      end
      kerq_pkg::CMD_OLD_EVAL: begin
        if (old_better) begin
          best_idx_r <= q_i_r;
          best_age_r <= q_age;
        end
      end
      kerq_pkg::CMD_Q_EVAL: begin
        if (q_cand && q_better) begin
          best_idx_r   <= q_i_r;
          best_age_r   <= q_age;
          best_time_r  <= qtime_r[q_i_r];
          best_key_r   <= qkey_r[q_i_r];
          best_press_r <= qpress_r[q_i_r];
        end
      end
      kerq_pkg::CMD_PUSH_WR: begin
        qtime_r[wr_slot]  <= time_r;
        qkey_r[wr_slot]   <= key_r;
        qpress_r[wr_slot] <= press_r;
        qorder_r[wr_slot] <= next_order_r;
      end
      default: begin
        best_idx_r <= best_idx_r;
      end
    endcase
    // packed deferral table: removal shifts the upper entries down
    if (rm_en) begin
      for (int j = 0; j < DD - 1; j++) begin
        if (j >= int'(d_idx)) begin
          dkey_r[j]  <= dkey_r[j + 1];
          dtime_r[j] <= dtime_r[j + 1];
          ddue_r[j]  <= ddue_r[j + 1];
        end
      end
    end
    if (app_en) begin
      dkey_r[dcount_r[DIW-1:0]]  <= best_key_r;
      dtime_r[dcount_r[DIW-1:0]] <= best_time_r;
      ddue_r[dcount_r[DIW-1:0]]  <= ps_q_r + {16'd0, min_hold_r};
    end
  end

  // press step memory
  always_ff @(posedge clk) begin
    if (cmd == kerq_pkg::CMD_PICK) begin
      if (best_press_r) press_step_mem[best_key_r] <= step_r;
      ps_q_r <= press_step_mem[best_key_r];
    end
  end

  // result buffer memory
  always_ff @(posedge clk) begin
    if (emit_en) obuf_mem[ocount_r[OIW-1:0]] <= {emit_key, emit_press, emit_time};
    if (cmd == kerq_pkg::CMD_OUT_RD) rdata_r <= obuf_mem[rd_idx_r];
  end

  assign status.mode       = mode_r;
  assign status.full       = full;
  assign status.q_last     = (q_i_r == QIW'(QD - 1));
  assign status.def_done   = (d_i_r >= dcount_r);
  assign status.found      = found_r;
  assign status.best_press = best_press_r;
  assign status.out_last   = (ocount_r == '0) ||
                             ({1'b0, rd_idx_r} == ocount_r - OCW'(1));

  always_comb begin
    out_data.has_event      = (ocount_r != '0);
    out_data.out_key        = out_data.has_event ? rdata_r[40:33] : 8'd0;
    out_data.out_press      = out_data.has_event ? rdata_r[32] : 1'b0;
    out_data.out_time       = out_data.has_event ? rdata_r[31:0] : 32'd0;
    out_data.last           = status.out_last;
    out_data.pending_count  = qpop + 6'(dcount_r);
    out_data.dropped_total  = drop_r;
    out_data.key_state      = qstate_r;
    out_data.defer_overflow = overflow_r;
  end

endmodule

### rtl/key_event_release_queue.sv
// top level of the key event release queue
//
// usage:
//   in channel (in_valid / in_stall / in_data) takes one command per transfer:
//   push an event, step tick, flush pending events, or query a key's state.
//   out channel (out_valid / out_stall / out_data) returns the results of that
//   command; the final result of each command has last set. a command that
//   releases nothing returns a single result with has_event clear.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the minimum hold in
//   steps; it is always ready. the user must write it only while the block is
//   idle; the block itself does not enforce this.
// sequencing (one command at a time; in_stall is low only in the idle state):
//   a push writes a free slot, or on a full queue overwrites the oldest entry
//   found by a 16-entry scan; flush and query go straight to results; a step
//   releases due deferred entries, then runs 16-entry selection passes with a
//   cancel scan after each press. each result is read from the buffer, then
//   transferred; the next input can come in the cycle after the last result.
// reset: synchronous active low; clears the queue, the deferral table, the
//   counters, key states and the minimum hold.
// stall: a result holds on out_data while out_stall is high.
module key_event_release_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kerq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kerq_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  kerq_pkg::cmd_t       cmd;
  kerq_pkg::dp_status_t status;

  // register writes never wait
  assign cfg_ready = 1'b1;

  kerq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  kerq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule

### tb/testbench.sv
// self-checking testbench for the key event release queue
module testbench;
  import kerq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  key_event_release_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------
  // predictor state: mirrors the block's queue, deferral table and key info
  // ---------------------------------------------------------------------
  logic [15:0] hold_steps;
  logic [31:0] q_time [QUEUE_DEPTH];
  logic [7:0]  q_key  [QUEUE_DEPTH];
  logic        q_press[QUEUE_DEPTH];
  logic [31:0] q_order[QUEUE_DEPTH];
  logic        q_vld  [QUEUE_DEPTH];
  // deferral table kept packed in deferral order
  logic [7:0]  d_key  [$];
  logic [31:0] d_time [$];
  logic [31:0] d_due  [$];
  logic [31:0] arrival_cnt;
  logic [31:0] step_cnt;
  logic [31:0] drop_cnt;
  logic [31:0] pressed_at [KEY_COUNT];
  logic        pressed_known [KEY_COUNT];
  logic        key_down [KEY_COUNT];
  logic        ovf_sticky;

  out_item_t expected_results[$];
  out_item_t released[$];

  int  errors;
  int  cycle_cnt;
  bit  sender_idle_mode;
  bit  receiver_stall_mode;
  bit  long_hold;

  function automatic int queue_fill();
    int n;
    n = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) if (q_vld[i]) n++;
    return n;
  endfunction

  function automatic void release_event(logic [7:0] key, logic press, logic [31:0] t);
    out_item_t r;
    r = '0;
    r.has_event = 1'b1;
    r.out_key   = key;
    r.out_press = press;
    r.out_time  = t;
    released.insert(released.size(), r);
    key_down[key] = press;
  endfunction

  function automatic void predict_push(in_item_t it);
    int slot, oldest;
    logic [31:0] age, best_age;
    if (queue_fill() >= QUEUE_DEPTH) begin
      oldest = -1;
      best_age = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        age = arrival_cnt - q_order[i];
        if (q_vld[i] && (oldest < 0 || age > best_age)) begin
          oldest = i;
          best_age = age;
        end
      end
      if (oldest >= 0) q_vld[oldest] = 1'b0;
      if (drop_cnt != 32'hffff_ffff) drop_cnt++;
    end
    slot = -1;
    for (int i = 0; i < QUEUE_DEPTH && slot < 0; i++) if (!q_vld[i]) slot = i;
    q_time[slot]  = it.event_time;
    q_key[slot]   = it.key_code;
    q_press[slot] = it.is_press;
    q_order[slot] = arrival_cnt;
    q_vld[slot]   = 1'b1;
    arrival_cnt++;
  endfunction

  function automatic void predict_step(logic [31:0] bnd);
    int i, best;
    logic [31:0] age, best_age, held;
    logic [7:0] k;
    logic [31:0] t;
    bit defer;
    step_cnt++;
    // deferred releases whose due step has come, oldest deferral first
    i = 0;
    while (i < d_key.size()) begin
      held = step_cnt - d_due[i];
      if (!held[31]) begin
        release_event(d_key[i], 1'b0, d_time[i]);
        d_key.delete(i); d_time.delete(i); d_due.delete(i);
      end else i++;
    end
    // queued events below the boundary by time, then arrival
    forever begin
      best = -1;
      best_age = '0;
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        age = arrival_cnt - q_order[j];
        if (!q_vld[j] || q_time[j] >= bnd) continue;
        if (best < 0 || q_time[j] < q_time[best] ||
            (q_time[j] == q_time[best] && age > best_age)) begin
          best = j;
          best_age = age;
        end
      end
      if (best < 0) break;
      q_vld[best] = 1'b0;
      k = q_key[best];
      t = q_time[best];
      if (q_press[best]) begin
        release_event(k, 1'b1, t);
        pressed_at[k] = step_cnt;
        pressed_known[k] = 1'b1;
        i = 0;
        while (i < d_key.size()) begin
          if (d_key[i] == k) begin
            d_key.delete(i); d_time.delete(i); d_due.delete(i);
          end else i++;
        end
      end else begin
        defer = 1'b0;
        if (hold_steps != 0 && pressed_known[k]) begin
          held = step_cnt - pressed_at[k];
          defer = held < {16'd0, hold_steps};
        end
        if (defer && d_key.size() < DEFER_DEPTH) begin
          d_key.insert(d_key.size(), k);
          d_time.insert(d_time.size(), t);
          d_due.insert(d_due.size(), pressed_at[k] + {16'd0, hold_steps});
        end else begin
          if (defer) ovf_sticky = 1'b1;
          release_event(k, 1'b0, t);
        end
      end
    end
  endfunction

  // works out every result one command causes and queues them
  function automatic void predict_command(in_item_t it);
    out_item_t r;
    logic qs;
    int n;
    released.delete();
    qs = 1'b0;
    case (it.mode)
      MODE_PUSH:  predict_push(it);
      MODE_STEP:  predict_step(it.boundary_time);
      MODE_FLUSH: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) q_vld[i] = 1'b0;
        d_key.delete(); d_time.delete(); d_due.delete();
      end
      default:    qs = key_down[it.key_code];
    endcase
    if (released.size() == 0) released.insert(0, '0);
    n = released.size();
    for (int i = 0; i < n; i++) begin
      r = released[i];
      r.last           = (i == n - 1);
      r.pending_count  = 6'(queue_fill() + d_key.size());
      r.dropped_total  = drop_cnt;
      r.key_state      = qs;
      r.defer_overflow = ovf_sticky;
      expected_results.insert(expected_results.size(), r);
    end
  endfunction

  // ---------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------
  task automatic send_command(in_item_t it);
    while (sender_idle_mode && $urandom_range(99) < 79) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    predict_command(it);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_hold(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hold_steps = v;
  endtask

  function automatic in_item_t make_cmd(logic [1:0] m, logic [7:0] k, logic p,
                                        logic [31:0] t, logic [31:0] b);
    in_item_t it;
    it.mode = m; it.key_code = k; it.is_press = p;
    it.event_time = t; it.boundary_time = b;
    return it;
  endfunction

  // random press/release traffic, mostly on keys 0 to 7, with occasional noise
  function automatic in_item_t random_cmd();
    int r;
    logic [7:0] k;
    r = $urandom_range(99);
    k = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    if (r < 55)
      return make_cmd(MODE_PUSH, k, 1'($urandom),
                      ($urandom_range(9) == 0) ? $urandom : $urandom_range(200),
                      $urandom);
    else if (r < 88)
      return make_cmd(MODE_STEP, k, 1'($urandom), $urandom,
                      ($urandom_range(9) == 0) ? $urandom : $urandom_range(250));
    else if (r < 92)
      return make_cmd(MODE_FLUSH, k, 1'($urandom), $urandom, $urandom);
    else
      return make_cmd(MODE_QUERY, k, 1'($urandom), $urandom, $urandom);
  endfunction

  // ---------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------
  task automatic test_directed_extremes();
    send_command(make_cmd(MODE_STEP, 8'h00, 1'b0, 32'h0, 32'h0));        // empty step
    send_command(make_cmd(MODE_PUSH, 8'hff, 1'b1, 32'hffff_fffe, 32'h0));
    send_command(make_cmd(MODE_PUSH, 8'h00, 1'b0, 32'h0, 32'hffff_ffff));
    send_command(make_cmd(MODE_PUSH, 8'h05, 1'b0, 32'h0, 32'h0));        // tie on time
    send_command(make_cmd(MODE_STEP, 8'h00, 1'b0, 32'h0, 32'hffff_ffff));
    send_command(make_cmd(MODE_QUERY, 8'hff, 1'b0, 32'h0, 32'h0));
    send_command(make_cmd(MODE_QUERY, 8'h00, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
    send_command(make_cmd(MODE_PUSH, 8'h10, 1'b1, 32'd5, 32'h0));
    send_command(make_cmd(MODE_FLUSH, 8'h00, 1'b0, 32'h0, 32'h0));
  endtask

  task automatic test_full_queue_drops();
    // overfill so the oldest arrival is dropped several times
    for (int i = 0; i < QUEUE_DEPTH + 4; i++)
      send_command(make_cmd(MODE_PUSH, 8'(i), 1'(i), 32'(100 - i), 32'h0));
    send_command(make_cmd(MODE_STEP, 8'h00, 1'b0, 32'h0, 32'hffff_ffff));
  endtask

  task automatic test_deferral(logic [15:0] hold);
    write_hold(hold);
    // press then quick release: deferred; a later press of key 2 runs the cancel scan
    for (int i = 0; i < DEFER_DEPTH + 2; i++)
      send_command(make_cmd(MODE_PUSH, 8'(i), 1'b1, 32'd1, 32'h0));
    send_command(make_cmd(MODE_STEP, 8'h00, 1'b0, 32'h0, 32'd2));
    for (int i = 0; i < DEFER_DEPTH + 2; i++)
      send_command(make_cmd(MODE_PUSH, 8'(i), 1'b0, 32'd3, 32'h0));
    send_command(make_cmd(MODE_PUSH, 8'd40, 1'b0, 32'd3, 32'h0));       // never pressed
    send_command(make_cmd(MODE_STEP, 8'h00, 1'b0, 32'h0, 32'd10));
    send_command(make_cmd(MODE_PUSH, 8'd2, 1'b1, 32'd4, 32'h0));
    send_command(make_cmd(MODE_STEP, 8'h00, 1'b0, 32'h0, 32'd10));
    for (int i = 0; i < 4; i++)
      send_command(make_cmd(MODE_STEP, 8'h00, 1'b0, 32'h0, 32'd0));
    send_command(make_cmd(MODE_QUERY, 8'd2, 1'b0, 32'h0, 32'h0));
    send_command(make_cmd(MODE_FLUSH, 8'h00, 1'b0, 32'h0, 32'h0));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_command(random_cmd());
  endtask

  task automatic test_backpressure();
    // receiver holds off a long while as commands keep coming
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_command(random_cmd());
    wait (!long_hold);
    // sender pauses until everything is back
    while (expected_results.size() != 0) @(posedge clk);
    test_random(10);
  endtask

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.has_event !== e.has_event || out_data.out_key !== e.out_key ||
            out_data.out_press !== e.out_press || out_data.out_time !== e.out_time ||
            out_data.last !== e.last || out_data.pending_count !== e.pending_count ||
            out_data.dropped_total !== e.dropped_total ||
            out_data.key_state !== e.key_state ||
            out_data.defer_overflow !== e.defer_overflow) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  // receiver stall, with a long hold-off counted here
  always @(posedge clk) begin
    int held;
    if (!rst_n) begin
      out_stall <= 1'b0;
      held = 0;
    end else if (long_hold) begin
      held++;
      if (held >= 3000) begin
        long_hold <= 1'b0;
        out_stall <= 1'b0;
        held = 0;
      end else begin
        out_stall <= 1'b1;
      end
    end else begin
      out_stall <= receiver_stall_mode && ($urandom_range(99) < 79);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 1500000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycle_cnt = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_stall = 1'b0;
    long_hold = 1'b0;
    sender_idle_mode = 1'b0;
    receiver_stall_mode = 1'b0;
    hold_steps = '0;
    arrival_cnt = '0; step_cnt = '0; drop_cnt = '0; ovf_sticky = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) q_vld[i] = 1'b0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      pressed_known[i] = 1'b0;
      key_down[i] = 1'b0;
      pressed_at[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_full_queue_drops();
    test_deferral(16'd3);
    test_random(80);                       // no idling
    write_hold(16'hffff);
    sender_idle_mode = 1'b1;
    test_random(80);
    write_hold(16'd1);
    sender_idle_mode = 1'b0;
    receiver_stall_mode = 1'b1;
    test_random(80);
    write_hold(16'd0);
    sender_idle_mode = 1'b1;
    test_random(50);
    write_hold(16'd2);
    sender_idle_mode = 1'b0;
    receiver_stall_mode = 1'b0;
    test_backpressure();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
